FILE: rtl/frt_pkg.sv
package frt_pkg;

  localparam int SLOT_COUNT_DEF    = 4;
  localparam int MAX_FRAGMENTS_DEF = 32;
  localparam int CHUNK_SIZE_DEF    = 32;
  localparam int MAX_PAYLOAD_DEF   = 1024;

  localparam logic [31:0] STALE_RESET = 32'd30000;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_PRUNE  = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_STORED   = 3'd3;
  localparam logic [2:0] ST_PRUNED   = 3'd4;
  localparam logic [2:0] ST_READ     = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] origin_id;
    logic [31:0] message_id;
    logic [7:0]  payload_type;
    logic [7:0]  hop_count;
    logic [4:0]  frag_index;
    logic [5:0]  frag_total;
    logic [10:0] message_length;
    logic [5:0]  chunk_length;
    logic [31:0] now_ms;
    logic [7:0]  data_byte;
    logic [9:0]  read_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  slot_number;
    logic [31:0] done_origin;
    logic [31:0] done_message;
    logic [7:0]  done_type;
    logic [7:0]  done_hops;
    logic [10:0] done_length;
    logic [2:0]  dropped_slots;
    logic [7:0]  read_byte;
  } out_item_t;

  // One slot record as held in the slot table.
  typedef struct packed {
    logic        active;
    logic [31:0] origin;
    logic [31:0] message;
    logic [7:0]  ptype;
    logic [7:0]  hops;
    logic [5:0]  total;
    logic [10:0] length;
    logic [31:0] received;
    logic [31:0] touched;
  } slot_t;

  // Payload store access request from the controller.
  typedef struct packed {
    logic        we;
    logic        re;
    logic [17:0] addr;
    logic [7:0]  wdata;
  } pay_req_t;

endpackage

FILE: rtl/frt_payload_ram.sv
module frt_payload_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                  clk,
  input  frt_pkg::pay_req_t     req,
  output logic [7:0]            rdata
);
  import frt_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr[AW-1:0]];
    end
  end

endmodule

FILE: rtl/frt_slot_table.sv
module frt_slot_table #(
  parameter int SLOTS = 4,
  parameter int SW    = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [SW-1:0]    waddr,
  input  frt_pkg::slot_t   wdata,
  input  logic             clr_we,
  input  logic [SLOTS-1:0] clr_mask,
  output frt_pkg::slot_t   rdata [SLOTS]
);
  import frt_pkg::*;

  // Small register file: every slot is read at its own fixed place by the
  // key-match and age search.
  slot_t slot_r [SLOTS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (!rst_n) begin
        slot_r[i] <= '0;
      end else if (clr_we && clr_mask[i]) begin
        slot_r[i] <= '0;
      end else if (we && waddr == SW'(i)) begin
        slot_r[i] <= wdata;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) rdata[i] = slot_r[i];
  end

endmodule

FILE: rtl/fragment_reassembly_table.sv
// Channel  | Ports                          | Transaction
// ---------+--------------------------------+------------------------------------
// input    | start, busy, in_item           | taken when start is high, busy low
// result   | out_strobe, out_item           | one cycle, receiver cannot stall
// config   | cfg_we, cfg_wdata              | written at any edge with cfg_we high
//
// The slot table is searched combinationally on the presented item, and the
// item and search outcome are registered at the taking edge. In the following
// cycle busy is high, the decision is made and the slot record is written at
// its closing edge, together with the result register. The result is strobed
// in the cycle after that, which is also the earliest cycle in which the next
// transaction can be taken, so the block takes no new transaction while busy.
// Read items use the payload memory port at the taking edge and
// return its data with the result. The receiver cannot stall the block.
// Synchronous active-low reset clears the slot table and all control state;
// the payload memory is not cleared.
module fragment_reassembly_table #(
  parameter int SLOT_COUNT    = frt_pkg::SLOT_COUNT_DEF,
  parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF,
  parameter int CHUNK_SIZE    = frt_pkg::CHUNK_SIZE_DEF,
  parameter int MAX_PAYLOAD   = frt_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  frt_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output frt_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);
  import frt_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int AW = SW + PW;
  localparam int CW = $clog2(CHUNK_SIZE + 1);

  logic [31:0] stale_r;
  logic        phase_r;
  in_item_t    item_r;

  // Pending fragment state.
  logic          pv_r;
  logic [SW-1:0] ps_r;
  logic [4:0]    pi_r;
  logic [CW-1:0] pw_r;
  logic [CW-1:0] pl_r;
  logic [SW-1:0] comp_r;

  slot_t          slots [SLOT_COUNT];
  logic           st_we;
  logic [SW-1:0]  st_waddr;
  slot_t          st_wdata;
  logic           st_clr;
  logic [SLOT_COUNT-1:0] st_mask;
  pay_req_t       preq;
  logic [7:0]     prdata;

  frt_slot_table #(.SLOTS(SLOT_COUNT), .SW(SW)) u_slots (
    .clk, .rst_n, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .clr_we(st_clr), .clr_mask(st_mask), .rdata(slots)
  );

  frt_payload_ram #(.DEPTH(SLOT_COUNT * (1 << PW)), .AW(AW)) u_ram (
    .clk, .req(preq), .rdata(prdata)
  );

  assign busy = phase_r;

  // First cycle: search results registered for the update cycle.
  logic          hit_r, free_r;
  logic [SW-1:0] hit_s_r, free_s_r, old_s_r;
  logic          hit_c;
  logic          free_c;
  logic [SW-1:0] hit_s_c, free_s_c, old_s_c;
  logic [31:0]   best_c;
  logic [31:0]   age_c;

  always_comb begin
    hit_c = 1'b0; free_c = 1'b0;
    hit_s_c = '0; free_s_c = '0; old_s_c = '0; best_c = '0; age_c = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!hit_c && slots[i].active && slots[i].origin == in_item.origin_id &&
          slots[i].message == in_item.message_id &&
          slots[i].ptype == in_item.payload_type) begin
        hit_c = 1'b1; hit_s_c = SW'(i);
      end
      if (!free_c && !slots[i].active) begin
        free_c = 1'b1; free_s_c = SW'(i);
      end
      age_c = in_item.now_ms - slots[i].touched;
      if (age_c > best_c) begin
        best_c = age_c; old_s_c = SW'(i);
      end
    end
  end

  // The payload port: bytes are written on the take cycle, reads issued.
  logic [PW+5:0] pos_c;
  always_comb begin
    pos_c = (PW+6)'(pi_r) * (PW+6)'(CHUNK_SIZE) + (PW+6)'(pw_r);
    preq = '0;
    if (start && !phase_r && in_item.kind == KIND_BYTE && pv_r &&
        pos_c < (PW+6)'(MAX_PAYLOAD)) begin
      preq.we    = 1'b1;
      preq.addr  = 18'({ps_r, pos_c[PW-1:0]});
      preq.wdata = in_item.data_byte;
    end else if (start && !phase_r && in_item.kind == KIND_READ) begin
      preq.re   = 1'b1;
      preq.addr = 18'({comp_r, in_item.read_offset[PW-1:0]});
    end
  end

  // Second cycle: decide, update slot record and produce the result.
  slot_t         s_c;
  out_item_t     res_c;
  logic          pv_nxt;
  logic [SW-1:0] ps_nxt;
  logic [4:0]    pi_nxt;
  logic [CW-1:0] pw_nxt, pl_nxt;
  logic [SW-1:0] comp_nxt;
  logic [SW-1:0] sel;
  logic          bad;
  logic [31:0]   fm, bit_c;
  logic          fin;
  logic [2:0]    ndrop;
  logic          rd_ok_r;

  always_comb begin
    res_c = '0; st_we = 1'b0; st_waddr = '0; st_wdata = '0;
    st_clr = 1'b0; st_mask = '0;
    pv_nxt = pv_r; ps_nxt = ps_r; pi_nxt = pi_r; pw_nxt = pw_r; pl_nxt = pl_r;
    comp_nxt = comp_r; sel = '0; s_c = '0; bad = 1'b0; fm = '0; bit_c = '0;
    fin = 1'b0; ndrop = '0;
    case (item_r.kind)
      KIND_HEADER: begin
        pv_nxt = 1'b0;
        res_c.status = ST_REJECTED;
        bad = item_r.frag_total == 6'd0 ||
              32'(item_r.frag_total) > 32'(MAX_FRAGMENTS) ||
              {1'b0, item_r.frag_index} >= item_r.frag_total ||
              32'(item_r.message_length) > 32'(MAX_PAYLOAD) ||
              32'(item_r.chunk_length) > 32'(CHUNK_SIZE) ||
              32'(item_r.frag_index) * 32'(CHUNK_SIZE) + 32'(item_r.chunk_length)
                > 32'(item_r.message_length);
        if (!bad) begin
          if (hit_r) begin
            sel = hit_s_r;
            s_c = slots[sel];
            if (s_c.total != item_r.frag_total || s_c.length != item_r.message_length)
              bad = 1'b1;
            else if (item_r.hop_count > s_c.hops)
              s_c.hops = item_r.hop_count;
          end else begin
            sel = free_r ? free_s_r : old_s_r;
            s_c.active  = 1'b1;
            s_c.origin  = item_r.origin_id;
            s_c.message = item_r.message_id;
            s_c.ptype   = item_r.payload_type;
            s_c.hops    = item_r.hop_count;
            s_c.total   = item_r.frag_total;
            s_c.length  = item_r.message_length;
            s_c.received = '0;
            // A free slot keeps its old touch time until set below.
            s_c.touched = free_r ? slots[sel].touched : 32'd0;
          end
          if (!bad) begin
            st_we = 1'b1; st_waddr = sel;
            bit_c = 32'd1 << item_r.frag_index;
            if ((s_c.received & bit_c) == '0) begin
              s_c.touched = item_r.now_ms;
              if (item_r.chunk_length == 6'd0) begin
                s_c.received = s_c.received | bit_c;
                fm = (s_c.total >= 6'd32) ? 32'hFFFF_FFFF
                                          : ((32'd1 << s_c.total) - 32'd1);
                fin = (s_c.received & fm) == fm;
              end else begin
                pv_nxt = 1'b1; ps_nxt = sel; pi_nxt = item_r.frag_index;
                pw_nxt = '0; pl_nxt = CW'(item_r.chunk_length);
              end
              res_c.status = ST_ACCEPTED;
              res_c.slot_number = 2'(sel);
            end
          end
        end
      end
      KIND_BYTE: begin
        if (!pv_r) begin
          res_c.status = ST_REJECTED;
        end else begin
          sel = ps_r;
          s_c = slots[sel];
          pw_nxt = pw_r + CW'(1);
          pl_nxt = pl_r - CW'(1);
          res_c.status = ST_STORED;
          res_c.slot_number = 2'(sel);
          if (pl_r == CW'(1)) begin
            pv_nxt = 1'b0;
            st_we = 1'b1; st_waddr = sel;
            s_c.received = s_c.received | (32'd1 << pi_r);
            fm = (s_c.total >= 6'd32) ? 32'hFFFF_FFFF
                                      : ((32'd1 << s_c.total) - 32'd1);
            fin = (s_c.received & fm) == fm;
          end
        end
      end
      KIND_PRUNE: begin
        res_c.status = ST_PRUNED;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slots[i].active && (item_r.now_ms - slots[i].touched) > stale_r) begin
            st_mask[i] = 1'b1;
            ndrop = ndrop + 3'd1;
            if (pv_r && ps_r == SW'(i)) pv_nxt = 1'b0;
          end
        end
        st_clr = 1'b1;
        res_c.dropped_slots = ndrop;
      end
      default: begin
        res_c.status = ST_READ;
        res_c.read_byte = rd_ok_r ? prdata : 8'd0;
      end
    endcase
    if (fin) begin
      res_c.status       = ST_COMPLETE;
      res_c.slot_number  = 2'(sel);
      res_c.done_origin  = s_c.origin;
      res_c.done_message = s_c.message;
      res_c.done_type    = s_c.ptype;
      res_c.done_hops    = s_c.hops;
      res_c.done_length  = s_c.length;
      comp_nxt = sel;
      s_c = '0;
    end
    st_wdata = s_c;
    if (!phase_r) begin
      st_we = 1'b0; st_clr = 1'b0;
      pv_nxt = pv_r; ps_nxt = ps_r; pi_nxt = pi_r; pw_nxt = pw_r; pl_nxt = pl_r;
      comp_nxt = comp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r <= STALE_RESET;
      phase_r <= 1'b0;
      out_strobe <= 1'b0;
      pv_r <= 1'b0; ps_r <= '0; pi_r <= '0; pw_r <= '0; pl_r <= '0;
      comp_r <= '0;
    end else begin
      if (cfg_we) stale_r <= cfg_wdata;
      phase_r <= start && !phase_r;
      out_strobe <= phase_r;
      pv_r <= pv_nxt; ps_r <= ps_nxt; pi_r <= pi_nxt; pw_r <= pw_nxt; pl_r <= pl_nxt;
      comp_r <= comp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !phase_r) begin
      item_r   <= in_item;
      hit_r    <= hit_c;   hit_s_r  <= hit_s_c;
      free_r   <= free_c;  free_s_r <= free_s_c;
      old_s_r  <= old_s_c;
      rd_ok_r  <= 32'(in_item.read_offset) < 32'(MAX_PAYLOAD);
    end
    if (phase_r) out_item <= res_c;
  end

endmodule

FILE: tb/sv/frt_scoreboard.sv
// Scoreboard for the fragment reassembly table: a slot-table predictor that
// works out the result of every accepted transaction, and a queue of the
// results still to come.
class frt_scoreboard;
  logic [31:0]       stale_limit;
  frt_pkg::slot_t    slots[4];
  bit                pend_valid;
  int unsigned       pend_slot;
  int unsigned       pend_index;
  int unsigned       pend_written;
  int unsigned       pend_left;
  int unsigned       last_done_slot;
  bit                byte_written[4096];
  frt_pkg::out_item_t pending_results[$];
  int                mismatch_count;
  int                failure_count;

  function new();
    stale_limit = frt_pkg::STALE_RESET;
    for (int i = 0; i < 4; i++) slots[i] = '0;
    pend_valid = 0;
    pend_slot = 0;
    pend_index = 0;
    pend_written = 0;
    pend_left = 0;
    last_done_slot = 0;
    foreach (byte_written[i]) byte_written[i] = 0;
    mismatch_count = 0;
    failure_count = 0;
  endfunction

  // Sets the fragment bit; fills the completion result and frees the slot
  // once every fragment has arrived.
  function bit set_fragment_bit(int unsigned s, int unsigned idx,
                                inout frt_pkg::out_item_t res);
    logic [31:0] mask;
    slots[s].received[idx[4:0]] = 1'b1;
    mask = (slots[s].total >= 32) ? 32'hFFFF_FFFF : ((32'd1 << slots[s].total) - 32'd1);
    if ((slots[s].received & mask) != mask) return 0;
    res.status       = frt_pkg::ST_COMPLETE;
    res.slot_number  = s[1:0];
    res.done_origin  = slots[s].origin;
    res.done_message = slots[s].message;
    res.done_type    = slots[s].ptype;
    res.done_hops    = slots[s].hops;
    res.done_length  = slots[s].length;
    last_done_slot = s;
    slots[s] = '0;
    return 1;
  endfunction

  function frt_pkg::out_item_t predict_header(frt_pkg::in_item_t it);
    frt_pkg::out_item_t res;
    int unsigned s;
    bit found;
    bit free_found;
    logic [31:0] best_age;
    logic [31:0] age;
    res = '0;
    res.status = frt_pkg::ST_REJECTED;
    pend_valid = 0;
    if (it.frag_total == 0 || it.frag_total > 32 || it.frag_index >= it.frag_total) return res;
    if (it.message_length > 1024 || it.chunk_length > 32) return res;
    if (int'(it.frag_index) * 32 + int'(it.chunk_length) > int'(it.message_length)) return res;
    s = 0;
    found = 0;
    for (int i = 0; i < 4 && !found; i++) begin
      if (slots[i].active && slots[i].origin == it.origin_id &&
          slots[i].message == it.message_id && slots[i].ptype == it.payload_type) begin
        s = i;
        found = 1;
      end
    end
    if (found) begin
      if (slots[s].total != it.frag_total || slots[s].length != it.message_length) return res;
      if (it.hop_count > slots[s].hops) slots[s].hops = it.hop_count;
    end else begin
      free_found = 0;
      for (int i = 0; i < 4 && !free_found; i++) begin
        if (!slots[i].active) begin
          s = i;
          free_found = 1;
        end
      end
      if (!free_found) begin
        s = 0;
        best_age = 0;
        for (int i = 0; i < 4; i++) begin
          age = it.now_ms - slots[i].touched;
          if (age > best_age) begin
            best_age = age;
            s = i;
          end
        end
        slots[s] = '0;
      end
      slots[s].active   = 1'b1;
      slots[s].origin   = it.origin_id;
      slots[s].message  = it.message_id;
      slots[s].ptype    = it.payload_type;
      slots[s].total    = it.frag_total;
      slots[s].length   = it.message_length;
      slots[s].received = '0;
      slots[s].hops     = it.hop_count;
    end
    if (slots[s].received[it.frag_index]) return res;
    slots[s].touched = it.now_ms;
    if (it.chunk_length == 0) begin
      if (set_fragment_bit(s, it.frag_index, res)) return res;
    end else begin
      pend_valid = 1;
      pend_slot = s;
      pend_index = it.frag_index;
      pend_written = 0;
      pend_left = it.chunk_length;
    end
    res.status = frt_pkg::ST_ACCEPTED;
    res.slot_number = s[1:0];
    return res;
  endfunction

  function frt_pkg::out_item_t predict_byte(frt_pkg::in_item_t it);
    frt_pkg::out_item_t res;
    int unsigned pos;
    res = '0;
    if (!pend_valid) begin
      res.status = frt_pkg::ST_REJECTED;
      return res;
    end
    pos = pend_index * 32 + pend_written;
    if (pos < 1024) byte_written[pend_slot * 1024 + pos] = 1;
    pend_written++;
    pend_left--;
    if (pend_left == 0) begin
      pend_valid = 0;
      if (set_fragment_bit(pend_slot, pend_index, res)) return res;
    end
    res.status = frt_pkg::ST_STORED;
    res.slot_number = pend_slot[1:0];
    return res;
  endfunction

  function frt_pkg::out_item_t predict_prune(frt_pkg::in_item_t it);
    frt_pkg::out_item_t res;
    int unsigned n;
    res = '0;
    n = 0;
    for (int i = 0; i < 4; i++) begin
      if (slots[i].active && (it.now_ms - slots[i].touched) > stale_limit) begin
        slots[i] = '0;
        if (pend_valid && pend_slot == i) pend_valid = 0;
        n++;
      end
    end
    res.status = frt_pkg::ST_PRUNED;
    res.dropped_slots = n[2:0];
    return res;
  endfunction

  // Called for every accepted input transaction.
  function void note_input(frt_pkg::in_item_t it);
    frt_pkg::out_item_t res;
    case (it.kind)
      frt_pkg::KIND_HEADER: res = predict_header(it);
      frt_pkg::KIND_BYTE:   res = predict_byte(it);
      frt_pkg::KIND_PRUNE:  res = predict_prune(it);
      default: begin
        // Store contents are not modelled; the byte is kept by the driver.
        res = '0;
        res.status = frt_pkg::ST_READ;
      end
    endcase
    pending_results.push_back(res);
  endfunction

  // Returns an offset in the completed region that has been written, if any.
  function bit pick_read_offset(output logic [9:0] off);
    int unsigned hits[$];
    off = 0;
    for (int i = 0; i < 1024; i++)
      if (byte_written[last_done_slot * 1024 + i]) hits.push_back(i);
    if (hits.size() == 0) return 0;
    off = hits[$urandom_range(0, hits.size() - 1)];
    return 1;
  endfunction

  function void check_result(frt_pkg::out_item_t act);
    frt_pkg::out_item_t exp;
    bit bad;
    if (pending_results.size() == 0) begin
      failure_count++;
      mismatch_count++;
      if (mismatch_count <= 10) $display("Unexpected result with nothing expected: %p", act);
      return;
    end
    exp = pending_results.pop_front();
    bad = (act.status !== exp.status) || (act.slot_number !== exp.slot_number) ||
          (act.done_origin !== exp.done_origin) || (act.done_message !== exp.done_message) ||
          (act.done_type !== exp.done_type) || (act.done_hops !== exp.done_hops) ||
          (act.done_length !== exp.done_length) ||
          (act.dropped_slots !== exp.dropped_slots) ||
          (act.read_byte !== exp.read_byte);
    if (bad) begin
      failure_count++;
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("Result mismatch at %0t", $realtime);
        $display("  expected %p", exp);
        $display("  actual   %p", act);
      end
    end
  endfunction
endclass

FILE: tb/sv/tb_fragment_reassembly_table.sv
module tb_fragment_reassembly_table;
  timeunit 1ns;
  timeprecision 1ps;
  import frt_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_item;
  logic       out_strobe;
  out_item_t  out_item;
  logic       cfg_we;
  logic [31:0] cfg_wdata;

  fragment_reassembly_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  frt_scoreboard board = new();

  // The driver keeps its own copy of every stored byte, since the scoreboard
  // only tracks which store entries have been written. A read result takes
  // its expected byte from here at the moment the read is accepted.
  logic [7:0] store_copy[4096];

  bit          gaps_on = 1;
  int          item_count = 0;
  int          quiet_cycles = 0;
  logic [31:0] clock_ms = 32'd1000;

  localparam int QUIET_LIMIT = 5000;
  localparam int ITEMS_TOTAL = 1300;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Results cannot be held off, so every strobed cycle is one transaction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_result(out_item);
  end

  // The watchdog counts cycles in which no transaction happens on either side.
  always @(posedge clk) begin
    if (!rst_n || out_strobe || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Presents one input transaction and waits until the block takes it. An
  // optional idle burst comes first; start is otherwise left high between
  // back-to-back transactions.
  task automatic send(in_item_t it);
    int unsigned slot_of_byte;
    int unsigned pos;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    // Work out which store entry a chunk byte lands in before the predictor
    // moves its pending state on.
    if (it.kind == KIND_BYTE && board.pend_valid) begin
      slot_of_byte = board.pend_slot;
      pos = board.pend_index * 32 + board.pend_written;
      store_copy[slot_of_byte * 1024 + pos] = it.data_byte;
    end
    board.note_input(it);
    if (it.kind == KIND_READ)
      board.pending_results[$].read_byte = store_copy[board.last_done_slot * 1024 + it.read_offset];
    item_count++;
  endtask

  // Drops start and waits until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_stale_limit(logic [31:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.stale_limit = value;
  endtask

  function automatic in_item_t make_header(logic [31:0] origin, logic [31:0] msg,
                                           logic [7:0] ptype, logic [7:0] hops,
                                           int idx, int total, int len, int clen);
    in_item_t it;
    it = '0;
    it.kind = KIND_HEADER;
    it.origin_id = origin;
    it.message_id = msg;
    it.payload_type = ptype;
    it.hop_count = hops;
    it.frag_index = idx[4:0];
    it.frag_total = total[5:0];
    it.message_length = len[10:0];
    it.chunk_length = clen[5:0];
    it.now_ms = clock_ms;
    it.data_byte = 8'($urandom);
    it.read_offset = 10'($urandom);
    return it;
  endfunction

  task automatic send_bytes(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = '0;
      it.kind = KIND_BYTE;
      it.data_byte = 8'($urandom);
      send(it);
    end
  endtask

  task automatic send_prune(logic [31:0] now);
    in_item_t it;
    it = '0;
    it.kind = KIND_PRUNE;
    it.now_ms = now;
    send(it);
  endtask

  // Reads a written byte of the last completed message, where one exists.
  task automatic send_read();
    in_item_t it;
    logic [9:0] off;
    if (board.pick_read_offset(off)) begin
      it = '0;
      it.kind = KIND_READ;
      it.read_offset = off;
      send(it);
    end
  endtask

  // Sends one message as a well-formed sequence of fragments in random order.
  // With broken set, one fragment loses some of its bytes and is cut short by
  // the next header; duplicates are slipped in now and then.
  task automatic send_message(logic [31:0] origin, logic [31:0] msg, logic [7:0] ptype,
                              int total, bit broken);
    int order[$];
    int len;
    int clen;
    int idx;
    int cut;
    int tmp;
    int j;
    len = (total - 1) * 32 + $urandom_range(0, 32);
    for (int i = 0; i < total; i++) order.push_back(i);
    for (int i = total - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    cut = broken ? $urandom_range(0, total - 1) : -1;
    for (int i = 0; i < total; i++) begin
      idx = order[i];
      clen = (idx == total - 1) ? len - idx * 32 : 32;
      clock_ms += $urandom_range(0, 50);
      send(make_header(origin, msg, ptype, 8'($urandom), idx, total, len, clen));
      if (i == cut && clen > 0) send_bytes($urandom_range(0, clen - 1));
      else send_bytes(clen);
      if ($urandom_range(0, 9) == 0) begin
        send(make_header(origin, msg, ptype, 8'($urandom), idx, total, len, clen));
        send_bytes($urandom_range(0, 2));
      end
    end
  endtask

  task automatic directed_part();
    // Chunk byte with no fragment pending, and a prune of an empty table.
    send_bytes(1);
    send_prune(32'h0);
    // Invalid headers: zero count, count too high, index not below count,
    // length too high, chunk too long and chunk past the message end.
    send(make_header(32'h1, 32'h1, 8'h1, 8'h0, 0, 0, 10, 5));
    send(make_header(32'h1, 32'h1, 8'h1, 8'h0, 0, 33, 10, 5));
    send(make_header(32'h1, 32'h1, 8'h1, 8'h0, 31, 31, 1024, 5));
    send(make_header(32'h1, 32'h1, 8'h1, 8'h0, 0, 1, 1025, 5));
    send(make_header(32'h1, 32'h1, 8'h1, 8'h0, 0, 1, 100, 33));
    send(make_header(32'h1, 32'h1, 8'h1, 8'h0, 1, 2, 40, 9));
    // A read before any completion reads the region of slot zero.
    send(make_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 0, 2, 64, 2));
    send_bytes(2);
    send_read();
    // Same key with another count, then a duplicate of fragment zero.
    send(make_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'h00, 1, 3, 64, 0));
    send(make_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'h01, 0, 2, 64, 2));
    // The second fragment arrives empty and completes the message on its header.
    send(make_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'h10, 1, 2, 64, 0));
    send_read();
    // Empty single-fragment message of length zero.
    send(make_header(32'h0, 32'h0, 8'h0, 8'h0, 0, 1, 0, 0));
    // A pending fragment cut off by a prune that drops its slot.
    send(make_header(32'h5, 32'h6, 8'h7, 8'h8, 0, 1, 32, 32));
    send_bytes(3);
    send_prune(clock_ms + 32'd40000);
    send_bytes(1);
  endtask

  task automatic random_part(int target);
    in_item_t it;
    int pick;
    while (item_count < target) begin
      gaps_on = (item_count <= (ITEMS_TOTAL * 4) / 5);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // Small key pool so that headers meet active slots and evictions.
        send_message($urandom_range(0, 2), $urandom_range(0, 2), 8'($urandom_range(0, 1)),
                     ($urandom_range(0, 29) == 0) ? 32 : $urandom_range(1, 4),
                     $urandom_range(0, 3) == 0);
        repeat ($urandom_range(0, 3)) send_read();
      end else if (pick < 70) begin
        // Noise header with every field random.
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.kind = KIND_HEADER;
        send(it);
      end else if (pick < 78) begin
        send_bytes($urandom_range(1, 3));
      end else if (pick < 88) begin
        clock_ms += ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200);
        send_prune(($urandom_range(0, 5) == 0) ? $urandom : clock_ms);
      end else begin
        repeat ($urandom_range(1, 4)) send_read();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    foreach (store_copy[i]) store_copy[i] = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_part();
    write_stale_limit(32'h0);
    send_prune(clock_ms);
    random_part(300);
    write_stale_limit(32'hFFFF_FFFF);
    random_part(600);
    write_stale_limit(32'd100);
    random_part(950);
    write_stale_limit($urandom_range(0, 1000));
    random_part(ITEMS_TOTAL);

    drain();
    repeat (10) @(posedge clk);
    if (board.failure_count == 0 && board.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
